// File: rtl/core/sswc_pkg.sv
// ----------------------------------------------------------------------------
// sswc_pkg
// Shared constants and types for the single-substitution word corrector.
// ----------------------------------------------------------------------------
package sswc_pkg;

  localparam int MaxLenDefault    = 32;
  localparam int DictWordsDefault = 64;
  localparam int CharW            = 8;
  localparam int ActW             = 2;

  typedef enum logic [ActW-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

endpackage

// File: rtl/core/sswc_if.sv
// ----------------------------------------------------------------------------
// sswc_in_if / sswc_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface sswc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] char_in;
  logic       word_end;
  modport source (output valid, action, char_in, word_end, input ready);
  modport sink   (input valid, action, char_in, word_end, output ready);
endinterface

interface sswc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_out;
  logic       found;
  logic       corrected;
  modport source (output valid, char_out, last_out, found, corrected, input ready);
  modport sink   (input valid, char_out, last_out, found, corrected, output ready);
endinterface

// File: rtl/core/single_substitution_word_corrector.sv
// ----------------------------------------------------------------------------
// single_substitution_word_corrector
// Dictionary match within one substituted character, top level.
// ----------------------------------------------------------------------------
// A load, clear or query character is accepted directly, but loads wait while a
// scan is running and a query word end waits until the previous word has
// been fully emitted. A word end starts a scan: an entry of wrong length
// is skipped after its length is read and checked, an entry of equal length
// is compared character by character with a final check after the last
// compare, and a substitution reads the replacement character. The word
// then streams out one character at a time, each read from the query
// buffer through its registered port; the next query may buffer while the
// previous one scans, in the other half of the query buffer.
module single_substitution_word_corrector #(
  parameter int MaxLen    = sswc_pkg::MaxLenDefault,
  parameter int DictWords = sswc_pkg::DictWordsDefault
) (
  input logic         clk,
  input logic         rst,
  sswc_in_if.sink     in_ch,
  sswc_out_if.source  out_ch
);
  import sswc_pkg::*;

  localparam int PosW  = $clog2(MaxLen);
  localparam int LenW  = $clog2(MaxLen + 1);
  localparam int WordW = (DictWords > 1) ? $clog2(DictWords) : 1;
  localparam int CntW  = $clog2(DictWords + 1);

  logic             dwe, lwe, qwe, qbank, rbank;
  logic [WordW-1:0] dword, rword;
  logic [PosW-1:0]  dpos, qpos, rpos, qrpos;
  logic [7:0]       dchar, qchar_w, rchar, qchar_r;
  logic [LenW-1:0]  llen, rlen, job_len;
  logic             job_valid, job_ready, job_bank, bank_busy;
  logic [CntW-1:0]  job_count;

  sswc_front #(.MaxLen(MaxLen), .DictWords(DictWords)) u_front (
    .clk, .rst, .in_ch,
    .dwe, .dword, .dpos, .dchar, .lwe, .llen,
    .qwe, .qbank, .qpos, .qchar(qchar_w),
    .job_valid, .job_ready, .job_len, .job_bank, .job_count, .bank_busy
  );

  sswc_ram #(.Width(CharW), .Depth(2 ** (WordW + PosW))) u_dict (
    .clk, .we(dwe), .waddr({dword, dpos}), .wdata(dchar),
    .raddr({rword, rpos}), .rdata(rchar)
  );

  sswc_ram #(.Width(LenW), .Depth(2 ** WordW)) u_len (
    .clk, .we(lwe), .waddr(dword), .wdata(llen), .raddr(rword), .rdata(rlen)
  );

  sswc_ram #(.Width(CharW), .Depth(2 ** (PosW + 1))) u_qbuf (
    .clk, .we(qwe), .waddr({qbank, qpos}), .wdata(qchar_w),
    .raddr({rbank, qrpos}), .rdata(qchar_r)
  );

  sswc_back #(.MaxLen(MaxLen), .DictWords(DictWords)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job_len, .job_bank, .job_count,
    .bank_busy, .rword, .rpos, .rchar, .rlen, .rbank, .qrpos,
    .qchar(qchar_r), .out_ch
  );
endmodule

// File: rtl/core/sswc_ram.sv
// ----------------------------------------------------------------------------
// sswc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sswc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/sswc_front.sv
// ----------------------------------------------------------------------------
// sswc_front
// Accepts input items, writes dictionary and query buffers, and queues a
// scan job (query length) for the back end at each query word end.
// ----------------------------------------------------------------------------
module sswc_front #(
  parameter int MaxLen    = 32,
  parameter int DictWords = 64,
  localparam int PosW  = $clog2(MaxLen),
  localparam int LenW  = $clog2(MaxLen + 1),
  localparam int WordW = (DictWords > 1) ? $clog2(DictWords) : 1,
  localparam int CntW  = $clog2(DictWords + 1)
) (
  input  logic                clk,
  input  logic                rst,
  sswc_in_if.sink             in_ch,
  // dictionary writes
  output logic                dwe,
  output logic [WordW-1:0]    dword,
  output logic [PosW-1:0]     dpos,
  output logic [7:0]          dchar,
  output logic                lwe,
  output logic [LenW-1:0]     llen,
  // query buffer writes
  output logic                qwe,
  output logic                qbank,
  output logic [PosW-1:0]     qpos,
  output logic [7:0]          qchar,
  // job queue to back end
  output logic                job_valid,
  input  logic                job_ready,
  output logic [LenW-1:0]     job_len,
  output logic                job_bank,
  output logic [CntW-1:0]     job_count,
  input  logic                bank_busy
);
  import sswc_pkg::*;

  logic [CntW-1:0] dict_count;
  logic [LenW-1:0] load_position;
  logic [LenW-1:0] query_length;
  logic            bank;
  logic            acc;
  action_t         act;
  logic [LenW-1:0] qlen_inc;
  logic [LenW-1:0] ld_inc;
  logic            full;
  logic            q_end;

  assign act   = action_t'(in_ch.action);
  assign full  = (dict_count >= CntW'(DictWords));
  // a word end needs a free job slot and a free buffer bank
  assign q_end = (act == ACT_QUERY) && in_ch.word_end;
  // loads wait while a scan may still read the dictionary
  assign in_ch.ready = !(q_end && (job_valid || bank_busy))
                       && !((act == ACT_QUERY) && (bank_busy && query_length == '0
                            && job_valid))
                       && !((act == ACT_LOAD) && (job_valid || bank_busy));
  assign acc = in_ch.valid && in_ch.ready;

  assign qlen_inc = (query_length < LenW'(MaxLen)) ? query_length + 1'b1 : query_length;
  assign ld_inc   = (load_position < LenW'(MaxLen)) ? load_position + 1'b1 : load_position;

  assign dwe   = acc && (act == ACT_LOAD) && !full && (load_position < LenW'(MaxLen));
  assign dword = dict_count[WordW-1:0];
  assign dpos  = load_position[PosW-1:0];
  assign dchar = in_ch.char_in;
  assign lwe   = acc && (act == ACT_LOAD) && !full && in_ch.word_end;
  assign llen  = ld_inc;

  assign qwe   = acc && (act == ACT_QUERY) && (query_length < LenW'(MaxLen));
  assign qbank = bank;
  assign qpos  = query_length[PosW-1:0];
  assign qchar = in_ch.char_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      dict_count    <= '0;
      load_position <= '0;
      query_length  <= '0;
      bank          <= 1'b0;
      job_valid     <= 1'b0;
      job_len       <= '0;
      job_bank      <= 1'b0;
      job_count     <= '0;
    end else begin
      if (job_valid && job_ready) begin
        job_valid <= 1'b0;
      end
      if (acc) begin
        unique case (act)
          ACT_LOAD: begin
            if (full) begin
              load_position <= '0;
            end else if (in_ch.word_end) begin
              dict_count    <= dict_count + 1'b1;
              load_position <= '0;
            end else begin
              load_position <= ld_inc;
            end
          end
          ACT_QUERY: begin
            if (in_ch.word_end) begin
              query_length <= '0;
              job_valid    <= 1'b1;
              job_len      <= qlen_inc;
              job_bank     <= bank;
              job_count    <= dict_count;
              bank         <= ~bank;
            end else begin
              query_length <= qlen_inc;
            end
          end
          ACT_CLEAR: begin
            dict_count    <= '0;
            load_position <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    dict_count <= CntW'(DictWords)) else $error("dictionary count overflow");
  a_qlen_bound: assert property (@(posedge clk) disable iff (rst)
    query_length <= LenW'(MaxLen)) else $error("query length overflow");
  a_job_hold: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid && $stable(job_len))
    else $error("job dropped");
`endif
endmodule

// File: rtl/core/sswc_back.sv
// ----------------------------------------------------------------------------
// sswc_back
// Scans the dictionary for a job, one character compare per cycle, applies
// the substitution and streams the word out through a registered output.
// ----------------------------------------------------------------------------
module sswc_back #(
  parameter int MaxLen    = 32,
  parameter int DictWords = 64,
  localparam int PosW  = $clog2(MaxLen),
  localparam int LenW  = $clog2(MaxLen + 1),
  localparam int WordW = (DictWords > 1) ? $clog2(DictWords) : 1,
  localparam int CntW  = $clog2(DictWords + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  logic [LenW-1:0]  job_len,
  input  logic             job_bank,
  input  logic [CntW-1:0]  job_count,
  output logic             bank_busy,
  // dictionary reads
  output logic [WordW-1:0] rword,
  output logic [PosW-1:0]  rpos,
  input  logic [7:0]       rchar,
  input  logic [LenW-1:0]  rlen,
  // query buffer reads
  output logic             rbank,
  output logic [PosW-1:0]  qrpos,
  input  logic [7:0]       qchar,
  sswc_out_if.source       out_ch
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LEN  = 6'b000010,
    S_CMP  = 6'b000100,
    S_FIX  = 6'b001000,
    S_RD   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t          state;
  logic [LenW-1:0] len;
  logic            bnk;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] word;
  logic [LenW-1:0] pos;
  logic            cmp_v;
  logic [PosW-1:0] cmp_pos;
  logic [1:0]      diffs;
  logic [PosW-1:0] where;
  logic            hit;
  logic            fixed;
  logic [7:0]      fix_char;
  logic            rd_v;
  logic [PosW-1:0] rd_pos;
  logic            pend;
  logic            mism;
  logic            ostall;

  assign ostall    = out_ch.valid && !out_ch.ready;
  assign job_ready = (state == S_IDLE);
  assign bank_busy = (state != S_IDLE);
  assign rbank     = bnk;
  assign rword     = word[WordW-1:0];
  assign mism      = cmp_v && (qchar != rchar);

  always_comb begin
    rpos  = pos[PosW-1:0];
    qrpos = pos[PosW-1:0];
    if (state == S_FIX) begin
      rpos = where;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cmp_v        <= 1'b0;
      diffs        <= '0;
      rd_v         <= 1'b0;
      pend         <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            len   <= job_len;
            bnk   <= job_bank;
            cnt   <= job_count;
            word  <= '0;
            hit   <= 1'b0;
            fixed <= 1'b0;
            state <= S_LEN;
          end
        end
        S_LEN: begin
          // the length of the word now on rword is registered and checked in S_CMP
          if (word >= cnt) begin
            pos   <= '0;
            state <= S_RD;
          end else begin
            pos   <= '0;
            diffs <= '0;
            cmp_v <= 1'b0;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (pos == '0 && !cmp_v && rlen != len) begin
            word  <= word + 1'b1;
            state <= S_LEN;
          end else begin
            if (mism) begin
              if (diffs == 2'd0) begin
                where <= cmp_pos;
              end
              diffs <= diffs + 1'b1;
            end
            if ((mism && diffs != 2'd0)) begin
              cmp_v <= 1'b0;
              word  <= word + 1'b1;
              state <= S_LEN;
            end else if (pos == len) begin
              if (!cmp_v) begin
                cmp_v <= 1'b0;
                hit   <= 1'b1;
                if (diffs != 2'd0 || mism) begin
                  fixed <= 1'b1;
                  state <= S_FIX;
                end else begin
                  pos   <= '0;
                  state <= S_RD;
                end
              end else begin
                cmp_v <= 1'b0;
              end
            end else begin
              cmp_v   <= 1'b1;
              cmp_pos <= pos[PosW-1:0];
              pos     <= pos + 1'b1;
            end
          end
        end
        S_FIX: begin
          if (!rd_v) begin
            rd_v <= 1'b1;
          end else begin
            rd_v     <= 1'b0;
            fix_char <= rchar;
            pos      <= '0;
            state    <= S_RD;
          end
        end
        S_RD: begin
          if (!ostall && !pend) begin
            if (pos == len) begin
              state <= S_IDLE;
            end else begin
              pend   <= 1'b1;
              rd_pos <= pos[PosW-1:0];
              pos    <= pos + 1'b1;
            end
          end else if (pend && !ostall) begin
            pend               <= 1'b0;
            out_ch.valid       <= 1'b1;
            out_ch.char_out    <= (fixed && rd_pos == where) ? fix_char : qchar;
            out_ch.last_out    <= (LenW'(rd_pos) + 1'b1 == len);
            out_ch.found       <= hit;
            out_ch.corrected   <= fixed;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    job_ready |-> !out_ch.valid || out_ch.last_out || !pend)
    else $error("job taken mid word");
  a_fix_hit: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.corrected |-> out_ch.found)
    else $error("corrected without found");
  a_diffs: assert property (@(posedge clk) disable iff (rst)
    diffs != 2'd3) else $error("diff count runaway");
`endif
endmodule
